### design/tmk_pkg.sv
// shared types and constants for the thin multipole kick block
package tmk_pkg;
    localparam int unsigned NumRegs   = 8;
    localparam int unsigned RegIdxW   = 3;
    localparam int unsigned FracShift = 28;
    localparam logic signed [31:0] AccMax = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic        [31:0] rigidity;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_mom_x;
        logic signed [31:0] new_mom_y;
        logic               saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_LOAD, ST_DIV, ST_FIN, ST_OUT
    } t_state;

    // one restoring-division cell result
    typedef struct packed {
        logic [59:0] rem;
        logic        qbit;
    } t_cell_out;
endpackage

### design/tmk_if.sv
// valid/ready channel interface
interface tmk_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/tmk_div_cell.sv
// one restoring division step: shifts in a dividend bit, subtracts the divisor when it fits
module tmk_div_cell
    import tmk_pkg::*;
(
    input  logic [59:0] i_rem,
    input  logic        i_bit,
    input  logic [31:0] i_div,
    output t_cell_out   o_res
);
    logic [60:0] w_sh;
    logic [60:0] w_diff;
    always_comb begin
        w_sh   = {i_rem, i_bit};
        w_diff = w_sh - {29'd0, i_div};
        if (!w_diff[60]) begin
            o_res.rem  = w_diff[59:0];
            o_res.qbit = 1'b1;
        end else begin
            o_res.rem  = w_sh[59:0];
            o_res.qbit = 1'b0;
        end
    end
endmodule

### design/tmk_div_chain.sv
// chain of two division cells; each cycle with i_step high retires two quotient bits of |S|*2^28/rigidity
module tmk_div_chain
    import tmk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_step,
    input  logic [59:0] i_num,
    input  logic [31:0] i_div,
    output logic [59:0] o_quot
);
    logic [59:0] r_rem;
    logic [59:0] r_num;
    logic [59:0] r_q;
    logic [31:0] r_div;
    t_cell_out   w_c0;
    t_cell_out   w_c1;

    tmk_div_cell u_c0 (.i_rem(r_rem), .i_bit(r_num[59]), .i_div(r_div), .o_res(w_c0));
    tmk_div_cell u_c1 (.i_rem(w_c0.rem), .i_bit(r_num[58]), .i_div(r_div), .o_res(w_c1));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_num <= i_num;
            r_div <= i_div;
            r_q   <= '0;
        end else if (i_step) begin
            r_rem <= w_c1.rem;
            r_num <= {r_num[57:0], 2'b00};
            r_q   <= {r_q[57:0], w_c0.qbit, w_c1.qbit};
        end
    end
    assign o_quot = r_q;
endmodule

### design/thin_multipole_kick.sv
// top level: horner evaluation of the multipole sum and momentum kick
//  channel | dir | payload
//  i_in    | in  | pos_x pos_y mom_x mom_y rigidity
//  o_out   | out | new_mom_x new_mom_y saturated
//  cfg     | in  | i_cfg_we i_cfg_idx i_cfg_data
// an item goes from request to result through the horner orders on the shared complex
// multiplier (a multiply state and an accumulate state per order), then for each momentum a
// load state and the two-cell chain (60-bit numerator, two bits a cycle), then finish and output.
// reset clears control and the strength registers; one item is worked at a time.
// the result waits in an output register; a stall holds it, no new item until taken,
// and the next request is accepted in the cycle after the result is taken.
module thin_multipole_kick
    import tmk_pkg::*;
#(
    parameter int MAX_ORDER = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RegIdxW-1:0]    i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    tmk_if.sink                   i_in,
    tmk_if.source                 o_out
);
    localparam int OrdW = 2;

    t_state              r_state, n_state;
    logic signed [31:0]  r_str [NumRegs];
    t_in_item            r_item;
    logic [31:0]         r_rig;
    logic signed [31:0]  r_ar, r_ai;
    logic signed [64:0]  r_pr, r_pi;
    logic [OrdW-1:0]     r_k;
    logic [4:0]          r_cnt;
    logic                r_part;
    logic [59:0]         r_qx;
    t_out_item           r_out;
    logic                r_ovld;

    logic                w_load, w_step;
    logic [59:0]         w_num, w_quot;

    function automatic logic signed [31:0] clip_acc(input logic signed [66:0] v);
        if (v > 67'sd2147483647) return AccMax;
        if (v < -67'sd2147483647) return -AccMax;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rnd_clip(input logic signed [64:0] p,
                                                    input logic signed [31:0] c);
        logic signed [64:0] t;
        logic signed [66:0] s;
        t = (p + 65'sd134217728) >>> FracShift;
        s = 67'(t) + 67'(c);
        return clip_acc(s);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] m,
                                                   input logic signed [31:0] s,
                                                   input logic [59:0] q,
                                                   output logic c);
        logic signed [62:0] k, v;
        k = s[31] ? -$signed({3'b0, q}) : $signed({3'b0, q});
        v = 63'(m) - k;
        c = 1'b0;
        if (v > 63'sd2147483647) begin
            c = 1'b1; return 32'sh7FFF_FFFF;
        end
        if (v < -63'sd2147483648) begin
            c = 1'b1; return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    tmk_div_chain u_div (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step),
        .i_num(w_num), .i_div(r_rig), .o_quot(w_quot)
    );

    logic [31:0] w_mag;
    always_comb begin
        w_mag = r_part ? (r_ai[31] ? -r_ai : r_ai) : (r_ar[31] ? -r_ar : r_ar);
        w_num = {w_mag, 28'd0};
    end

    logic signed [31:0] w_nx, w_ny;
    logic               w_cx, w_cy;
    always_comb begin
        w_nx = sat_sub(r_item.mom_x, r_ar, r_qx, w_cx);
        w_ny = sat_sub(r_item.mom_y, r_ai, w_quot, w_cy);
    end

    assign i_in.ready  = (r_state == ST_IDLE) && !r_ovld;
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) r_str[i] <= '0;
        end else if (i_cfg_we) begin
            r_str[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_step  = 1'b0;
        case (r_state)
            ST_IDLE: if (i_in.valid && i_in.ready) begin
                n_state = (MAX_ORDER == 0) ? ST_LOAD : ST_MUL;
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_k == '0) n_state = ST_LOAD;
                else           n_state = ST_MUL;
            end
            ST_LOAD: begin
                w_load  = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_step = 1'b1;
                if (r_cnt == 5'd29) n_state = r_part ? ST_FIN : ST_LOAD;
            end
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (i_in.valid && i_in.ready) begin
                r_item <= i_in.data;
                r_rig  <= (i_in.data.rigidity == '0) ? 32'd1 : i_in.data.rigidity;
                r_ar   <= clip_acc(67'(r_str[RegIdxW'(2*MAX_ORDER)]));
                r_ai   <= clip_acc(67'(r_str[RegIdxW'(2*MAX_ORDER+1)]));
                r_k    <= OrdW'(MAX_ORDER - 1);
                r_cnt  <= '0;
                r_part <= 1'b0;
            end
            ST_MUL: begin
                r_pr <= 65'(64'(r_ar) * 64'(r_item.pos_x)) - 65'(64'(r_ai) * 64'(r_item.pos_y));
                r_pi <= 65'(64'(r_ar) * 64'(r_item.pos_y)) + 65'(64'(r_ai) * 64'(r_item.pos_x));
            end
            ST_ACC: begin
                r_ar <= rnd_clip(r_pr, r_str[{r_k, 1'b0}]);
                r_ai <= rnd_clip(r_pi, r_str[{r_k, 1'b1}]);
                r_k  <= r_k - 1'b1;
            end
            // second load: the chain still holds the finished horizontal quotient
            ST_LOAD: if (r_part) r_qx <= w_quot;
            ST_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd29) begin
                    r_cnt  <= '0;
                    r_part <= 1'b1;
                end
            end
            ST_FIN: begin
                r_out.new_mom_x <= w_nx;
                r_out.new_mom_y <= w_ny;
                r_out.saturated <= w_cx | w_cy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                    r_ovld <= 1'b0;
        else if (r_state == ST_OUT)      r_ovld <= 1'b1;
        else if (o_out.ready)            r_ovld <= 1'b0;
    end
endmodule
